// File: rtl/wcd_pkg.sv
// Shared types, constants and helpers for the window consolidation detector.
`default_nettype none

package wcd_pkg;

   localparam int MaxWindow  = 64;
   localparam int AddrWidth  = $clog2(MaxWindow);
   localparam int CountWidth = 7;
   localparam int PriceWidth = 32;
   localparam int LimitWidth = PriceWidth + 4;
   localparam int ScoreWidth = CountWidth + 2;

   localparam logic [CountWidth-1:0] LengthReset = CountWidth'(30);
   localparam logic [CountWidth-1:0] MinLength   = CountWidth'(2);
   localparam logic [CountWidth-1:0] MaxLength   =
      CountWidth'((MaxWindow > 64) ? 64 : MaxWindow);
   localparam logic [CountWidth-1:0] FillLimit   = CountWidth'(MaxWindow);

   typedef struct packed {
      logic [PriceWidth-1:0] bar_high;
      logic [PriceWidth-1:0] bar_low;
      logic [PriceWidth-1:0] noise_level;
   } req_payload_type;

   typedef struct packed {
      logic                  window_full;
      logic                  consolidating;
      logic [CountWidth-1:0] midpoint_hits;
   } rsp_payload_type;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_START      = 7'b0000010,
      ST_SPAN       = 7'b0000100,
      ST_SPAN_DRAIN = 7'b0001000,
      ST_HITS       = 7'b0010000,
      ST_HITS_DRAIN = 7'b0100000,
      ST_DECIDE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic                  write;
      logic                  clear;
      logic                  rd_en;
      logic                  rd_hits;
      logic [CountWidth-1:0] pos;
      logic                  load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic                  window_full;
      logic [CountWidth-1:0] length;
   } dp_status_type;

   function automatic logic [CountWidth-1:0] effective_length(
      input logic [CountWidth-1:0] raw);
      logic [CountWidth-1:0] n;
      begin
         n = raw;
         if (n < MinLength) n = MinLength;
         if (n > MaxLength) n = MaxLength;
         return n;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/wcd_dp.sv
// Datapath: bar stores, window scans, accumulators and the result register.
`default_nettype none

module wcd_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wcd_pkg::req_payload_type            req_payload,
   input  wire logic                                csr_write,
   input  wire logic [wcd_pkg::CountWidth-1:0]      csr_data,
   input  wire wcd_pkg::dp_cmd_type                 cmd,
   output wcd_pkg::dp_status_type                   status,
   output wcd_pkg::rsp_payload_type                 rsp_payload
);

   logic [wcd_pkg::PriceWidth-1:0] high_mem [wcd_pkg::MaxWindow];
   logic [wcd_pkg::PriceWidth-1:0] low_mem  [wcd_pkg::MaxWindow];

   logic [wcd_pkg::CountWidth-1:0] length_ff, length_in;
   logic [wcd_pkg::AddrWidth-1:0]  wp_ff, wp_in;
   logic [wcd_pkg::CountWidth-1:0] fill_ff, fill_in;
   logic [wcd_pkg::LimitWidth-1:0] lim_ff, lim_in;

   logic                           rd_valid_ff;
   logic                           rd_hits_ff;
   logic [wcd_pkg::CountWidth-1:0] rd_pos_ff;
   logic [wcd_pkg::PriceWidth-1:0] rd_high_ff, rd_low_ff;

   logic [wcd_pkg::PriceWidth-1:0] wh_ff, wh_in, wl_ff, wl_in;
   logic [wcd_pkg::PriceWidth-1:0] h1_ff, h1_in, l1_ff, l1_in;
   logic [wcd_pkg::PriceWidth-1:0] h2_ff, h2_in, l2_ff, l2_in;
   logic [wcd_pkg::CountWidth-1:0] hits_ff, hits_in;
   logic [wcd_pkg::PriceWidth:0]   mid2_ff;
   logic [wcd_pkg::PriceWidth-1:0] diff_high_ff, diff_low_ff;
   wcd_pkg::rsp_payload_type       rsp_ff, rsp_in;

   logic [wcd_pkg::CountWidth-1:0] n;
   logic [wcd_pkg::CountWidth-1:0] half;
   logic [wcd_pkg::CountWidth-1:0] both_halves;
   logic [wcd_pkg::AddrWidth-1:0]  start_addr;
   logic [wcd_pkg::AddrWidth-1:0]  rd_addr;
   logic                           span_hit;
   logic [wcd_pkg::ScoreWidth-1:0] hits_x5;
   logic [wcd_pkg::ScoreWidth-1:0] len_x4;
   logic                           spread_ok;

   assign n           = wcd_pkg::effective_length(length_ff);
   assign half        = n >> 1;
   assign both_halves = {half[wcd_pkg::CountWidth-2:0], 1'b0};

   assign status.window_full = (fill_ff >= n);
   assign status.length      = n;

   // The oldest window bar sits n slots behind the next write slot.
   assign start_addr = wp_ff - n[wcd_pkg::AddrWidth-1:0];
   assign rd_addr    = start_addr + cmd.pos[wcd_pkg::AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         high_mem[wp_ff] <= req_payload.bar_high;
         low_mem[wp_ff]  <= req_payload.bar_low;
      end
   end

   always_ff @(posedge clock) begin
      rd_high_ff <= high_mem[rd_addr];
      rd_low_ff  <= low_mem[rd_addr];
   end

   always_comb begin
      length_in = csr_write ? csr_data : length_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      lim_in    = lim_ff;
      if (cmd.write) begin
         wp_in = wp_ff + 1'b1;
         if (fill_ff < wcd_pkg::FillLimit) fill_in = fill_ff + 1'b1;
         lim_in = ({4'b0000, req_payload.noise_level} << 3)
                + ({4'b0000, req_payload.noise_level} << 1);
      end
   end

   // A bar holds the midpoint when 2*low <= high+low of the window <= 2*high.
   assign span_hit = ({rd_high_ff, 1'b0} >= mid2_ff) && ({rd_low_ff, 1'b0} <= mid2_ff);

   always_comb begin
      wh_in   = wh_ff;
      wl_in   = wl_ff;
      h1_in   = h1_ff;
      l1_in   = l1_ff;
      h2_in   = h2_ff;
      l2_in   = l2_ff;
      hits_in = hits_ff;
      if (cmd.clear) begin
         wh_in   = '0;
         wl_in   = '1;
         h1_in   = '0;
         l1_in   = '1;
         h2_in   = '0;
         l2_in   = '1;
         hits_in = '0;
      end else if (rd_valid_ff && !rd_hits_ff) begin
         if (rd_high_ff > wh_ff) wh_in = rd_high_ff;
         if (rd_low_ff < wl_ff)  wl_in = rd_low_ff;
         if (rd_pos_ff < half) begin
            if (rd_high_ff > h1_ff) h1_in = rd_high_ff;
            if (rd_low_ff < l1_ff)  l1_in = rd_low_ff;
         end else if (rd_pos_ff < both_halves) begin
            if (rd_high_ff > h2_ff) h2_in = rd_high_ff;
            if (rd_low_ff < l2_ff)  l2_in = rd_low_ff;
         end
      end else if (rd_valid_ff && rd_hits_ff && span_hit) begin
         hits_in = hits_ff + 1'b1;
      end
   end

   assign hits_x5   = {hits_ff, 2'b00} + {2'b00, hits_ff};
   assign len_x4    = {n, 2'b00};
   assign spread_ok = ({4'b0000, diff_high_ff} <= lim_ff)
                   && ({4'b0000, diff_low_ff} <= lim_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_out) begin
         rsp_in.window_full   = status.window_full;
         rsp_in.consolidating = status.window_full && (hits_x5 >= len_x4) && spread_ok;
         rsp_in.midpoint_hits = status.window_full ? hits_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= wcd_pkg::LengthReset;
         wp_ff       <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         rd_valid_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      rd_hits_ff   <= cmd.rd_hits;
      rd_pos_ff    <= cmd.pos;
      wh_ff        <= wh_in;
      wl_ff        <= wl_in;
      h1_ff        <= h1_in;
      l1_ff        <= l1_in;
      h2_ff        <= h2_in;
      l2_ff        <= l2_in;
      hits_ff      <= hits_in;
      mid2_ff      <= {1'b0, wh_ff} + {1'b0, wl_ff};
      diff_high_ff <= (h1_ff >= h2_ff) ? (h1_ff - h2_ff) : (h2_ff - h1_ff);
      diff_low_ff  <= (l1_ff >= l2_ff) ? (l1_ff - l2_ff) : (l2_ff - l1_ff);
      rsp_ff       <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= wcd_pkg::FillLimit)
      else $error("fill count passed the store depth");

   a_hits_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (hits_ff <= n))
      else $error("midpoint hit count exceeds the window length");

   a_wp_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (wp_ff == $past(wp_ff) + 1'b1))
      else $error("write pointer did not advance after a stored bar");

endmodule

`default_nettype wire

// File: rtl/wcd_ctrl.sv
// Controller: sequences the write, the two window scans and the result hand-off.
`default_nettype none

module wcd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire wcd_pkg::dp_status_type status,
   output wcd_pkg::dp_cmd_type        cmd
);

   wcd_pkg::state_type             state_ff, state_in;
   logic [wcd_pkg::CountWidth-1:0] pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           last_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_pos  = (pos_ff == status.length - 1'b1);
   assign req_stall = (state_ff != wcd_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cmd          = '0;
      cmd.pos      = pos_ff;
      cmd.write    = req_valid && (state_ff == wcd_pkg::ST_IDLE);
      case (state_ff)
         wcd_pkg::ST_IDLE: begin
            if (req_valid) state_in = wcd_pkg::ST_START;
         end
         wcd_pkg::ST_START: begin
            cmd.clear = 1'b1;
            pos_in    = '0;
            state_in  = status.window_full ? wcd_pkg::ST_SPAN : wcd_pkg::ST_DECIDE;
         end
         wcd_pkg::ST_SPAN: begin
            cmd.rd_en = 1'b1;
            if (last_pos) begin
               pos_in   = '0;
               state_in = wcd_pkg::ST_SPAN_DRAIN;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         wcd_pkg::ST_SPAN_DRAIN: begin
            state_in = wcd_pkg::ST_HITS;
         end
         wcd_pkg::ST_HITS: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_hits = 1'b1;
            if (last_pos) begin
               pos_in   = '0;
               state_in = wcd_pkg::ST_HITS_DRAIN;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         wcd_pkg::ST_HITS_DRAIN: begin
            state_in = wcd_pkg::ST_DECIDE;
         end
         wcd_pkg::ST_DECIDE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = wcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)                    rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcd_pkg::ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcd_pkg::ST_SPAN || state_ff == wcd_pkg::ST_HITS)
         |-> (pos_ff < status.length))
      else $error("scan position ran past the window");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a stalled result waits");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_scan_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcd_pkg::ST_START && !status.window_full)
         |=> (state_ff == wcd_pkg::ST_DECIDE))
      else $error("scan started on a window that is not full");

endmodule

`default_nettype wire

// File: rtl/window_consolidation_detector.sv
// Top level of the window consolidation detector.
// Each request carries one price bar (high, low, noise level); the bar is
// written into a 64-entry ring store and the most recent N bars
// (window_length, clamped to 2..64, reset 30) are judged. Once N bars have
// arrived, the block scans the window twice through the single read port of
// the store: one pass collects the window maximum high and minimum low and
// the half-window spans, the next counts bars holding the midpoint. While
// the window is not yet full, both scans are skipped. The next request can
// be accepted in the cycle after the result is loaded. Requests are taken
// only while the controller is idle; a finished result waits in its output
// register, and a request accepted meanwhile gets its result loaded only
// once the waiting one has been taken. csr_ready is always high; the length
// register should be written only between requests.
`default_nettype none

module window_consolidation_detector (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire wcd_pkg::req_payload_type       req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output wcd_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [wcd_pkg::CountWidth-1:0] csr_data
);

   wcd_pkg::dp_cmd_type    cmd;
   wcd_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   wcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wcd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
